// ----- hw/rtl/prmf_pkg.sv -----
// ----------------------------------------------------------------------------
// prmf_pkg
// types and constants shared by the push-relabel maximum flow block
// ----------------------------------------------------------------------------
package prmf_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VTX_W        = $clog2(MAX_VERTICES);
    localparam int NV_W         = VTX_W + 1;
    localparam int MAX_EDGES    = 256;
    localparam int PAIR_W       = $clog2(MAX_EDGES);
    localparam int CNT_W        = PAIR_W + 1;
    localparam int CAP_W        = 32;
    localparam int HGT_W        = NV_W + 1;
    localparam int EXC_W        = CAP_W + PAIR_W + 1;
    localparam int ACC_W        = CAP_W + PAIR_W + 2;
    localparam int FLOW_W       = 40;

    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_RUN = 1'b1;

    typedef struct packed {
        logic              action;
        logic [VTX_W-1:0]  from_vertex;
        logic [VTX_W-1:0]  to_vertex;
        logic [CAP_W-1:0]  edge_capacity;
        logic [VTX_W-1:0]  source_vertex;
        logic [VTX_W-1:0]  sink_vertex;
    } prmf_req_t;

    typedef struct packed {
        logic [FLOW_W-1:0] total_flow;
        logic              bad_terminal;
        logic              table_overflow;
    } prmf_res_t;

    typedef struct packed {
        logic [VTX_W-1:0]  tail;
        logic [VTX_W-1:0]  head;
        logic [CAP_W-1:0]  cap;
    } prmf_edge_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SAT_RD,
        ST_SAT_CHK,
        ST_SAT_UPD,
        ST_DEQ_RD,
        ST_DEQ_POP,
        ST_VTX_LD,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_HGT_CHK,
        ST_PUSH_UPD,
        ST_SCAN_END,
        ST_WB,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_DONE
    } prmf_state_t;

endpackage

// ----- hw/rtl/push_relabel_max_flow.sv -----
// ----------------------------------------------------------------------------
// push_relabel_max_flow
// fifo push-relabel maximum flow over an on-chip edge table
// ----------------------------------------------------------------------------
// add-edge request: accepted while idle, busy stays low, no result
// run request: clear sweep, then a saturation pass over the edge pairs,
//   discharge scans over the pairs for each dequeued vertex, and a final sum
//   over the pairs; every pass reads the edge table through its registered port
// result strobe done lasts one cycle and cannot be stalled
// reset empties the edge table, clears the overflow mark, vertex count 64
module push_relabel_max_flow (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  prmf_pkg::prmf_req_t  request,
    output logic                 done,
    output prmf_pkg::prmf_res_t  result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [prmf_pkg::NV_W-1:0] cfg_data
);
    import prmf_pkg::*;

    prmf_state_t state_reg, state_next;

    logic [NV_W-1:0]           vcount_reg;
    logic [CNT_W-1:0]          ecount_reg, ecount_next;
    logic                      ovf_reg, ovf_next;
    logic [VTX_W-1:0]          src_reg, src_next, snk_reg, snk_next;
    logic [NV_W-1:0]           nv_reg, nv_next;
    logic [CNT_W-1:0]          p_reg, p_next;
    logic [VTX_W-1:0]          fhead_reg, fhead_next;
    logic [NV_W-1:0]           fcnt_reg, fcnt_next;
    logic [MAX_VERTICES-1:0]   queued_reg, queued_next;
    logic [VTX_W-1:0]          u_reg, u_next, v_reg, v_next;
    logic [HGT_W-1:0]          uh_reg, uh_next;
    logic signed [EXC_W-1:0]   uex_reg, uex_next;
    logic                      any_reg, any_next, minv_reg, minv_next;
    logic [HGT_W-1:0]          min_reg, min_next;
    logic [CAP_W:0]            resid_reg, resid_next;
    logic [CAP_W-1:0]          f_reg, f_next;
    logic                      slot_reg, slot_next;
    logic signed [EXC_W-1:0]   amt_reg, amt_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic                      bad_reg, bad_next;

    prmf_edge_t                edge_mem [MAX_EDGES];
    logic [CAP_W-1:0]          flow_mem [MAX_EDGES];
    logic [HGT_W-1:0]          hgt_mem  [MAX_VERTICES];
    logic signed [EXC_W-1:0]   exc_mem  [MAX_VERTICES];
    logic [VTX_W-1:0]          fifo_mem [MAX_VERTICES];

    prmf_edge_t                edge_q;
    logic [CAP_W-1:0]          flow_q;
    logic [HGT_W-1:0]          hgt_q;
    logic signed [EXC_W-1:0]   exc_q;
    logic [VTX_W-1:0]          fifo_q;

    logic                      edge_we, flow_we, hgt_we, exc_we, fifo_we;
    logic [PAIR_W-1:0]         edge_wa, edge_ra, flow_wa, flow_ra;
    prmf_edge_t                edge_wd;
    logic [CAP_W-1:0]          flow_wd;
    logic [VTX_W-1:0]          hgt_wa, hgt_ra, exc_wa, exc_ra, fifo_wa;
    logic [HGT_W-1:0]          hgt_wd;
    logic signed [EXC_W-1:0]   exc_wd;

    logic                      accept, run_req, bad_run;
    logic [NV_W-1:0]           nv_eff;
    logic                      usable, eligible, scan_done;
    logic signed [EXC_W-1:0]   new_exc, resid_ext;
    logic                      enq_try, enq_ok;
    logic [VTX_W-1:0]          enq_v;

    assign accept    = start && !busy;
    assign run_req   = accept && (request.action == ACT_RUN);
    assign nv_eff    = (vcount_reg > NV_W'(MAX_VERTICES)) ? NV_W'(MAX_VERTICES) : vcount_reg;
    assign bad_run   = ({1'b0, request.source_vertex} >= nv_eff)
                    || ({1'b0, request.sink_vertex} >= nv_eff);
    assign usable    = ({1'b0, edge_q.tail} < nv_reg) && ({1'b0, edge_q.head} < nv_reg)
                    && (edge_q.tail != edge_q.head);
    assign scan_done = (p_reg == ecount_reg);
    assign resid_ext = EXC_W'(resid_reg);

    always_comb
    begin
        eligible = 1'b0;
        if (usable && edge_q.tail == u_reg)
            eligible = (edge_q.cap != flow_q);
        else if (usable && edge_q.head == u_reg)
            eligible = (flow_q != '0);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (run_req) state_next = bad_run ? ST_DONE : ST_CLEAR;
            ST_CLEAR:    if (p_reg[PAIR_W-1:0] == PAIR_W'(MAX_EDGES - 1)) state_next = ST_SAT_RD;
            ST_SAT_RD:   state_next = scan_done ? ST_DEQ_RD : ST_SAT_CHK;
            ST_SAT_CHK:  state_next = (edge_q.tail == src_reg && usable && edge_q.cap != '0)
                                      ? ST_SAT_UPD : ST_SAT_RD;
            ST_SAT_UPD:  state_next = ST_SAT_RD;
            ST_DEQ_RD:   state_next = (fcnt_reg == '0) ? ST_SUM_RD : ST_DEQ_POP;
            ST_DEQ_POP:  state_next = (fifo_q == src_reg || fifo_q == snk_reg)
                                      ? ST_DEQ_RD : ST_VTX_LD;
            ST_VTX_LD:   state_next = (exc_q > 0) ? ST_SCAN_RD : ST_WB;
            ST_SCAN_RD:  state_next = scan_done ? ST_SCAN_END : ST_SCAN_CHK;
            ST_SCAN_CHK: state_next = eligible ? ST_HGT_CHK : ST_SCAN_RD;
            ST_HGT_CHK:  state_next = (uh_reg == hgt_q + HGT_W'(1) && uex_reg > 0)
                                      ? ST_PUSH_UPD : ST_SCAN_RD;
            ST_PUSH_UPD: state_next = ST_SCAN_RD;
            ST_SCAN_END:
            begin
                if (any_reg)
                    state_next = (uex_reg > 0) ? ST_SCAN_RD : ST_WB;
                else
                    state_next = minv_reg ? ST_SCAN_RD : ST_WB;
            end
            ST_WB:       state_next = ST_DEQ_RD;
            ST_SUM_RD:   state_next = scan_done ? ST_DONE : ST_SUM_ACC;
            ST_SUM_ACC:  state_next = ST_SUM_RD;
            ST_DONE:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        ecount_next = ecount_reg;
        ovf_next    = ovf_reg;
        src_next    = src_reg;
        snk_next    = snk_reg;
        nv_next     = nv_reg;
        p_next      = p_reg;
        fhead_next  = fhead_reg;
        fcnt_next   = fcnt_reg;
        queued_next = queued_reg;
        u_next      = u_reg;
        v_next      = v_reg;
        uh_next     = uh_reg;
        uex_next    = uex_reg;
        any_next    = any_reg;
        minv_next   = minv_reg;
        min_next    = min_reg;
        resid_next  = resid_reg;
        f_next      = f_reg;
        slot_next   = slot_reg;
        amt_next    = amt_reg;
        acc_next    = acc_reg;
        bad_next    = bad_reg;

        edge_we = 1'b0;
        edge_wa = ecount_reg[PAIR_W-1:0];
        edge_wd = '{tail: request.from_vertex, head: request.to_vertex,
                    cap: request.edge_capacity};
        edge_ra = p_reg[PAIR_W-1:0];
        flow_we = 1'b0;
        flow_wa = p_reg[PAIR_W-1:0];
        flow_wd = '0;
        flow_ra = p_reg[PAIR_W-1:0];
        hgt_we  = 1'b0;
        hgt_wa  = p_reg[VTX_W-1:0];
        hgt_wd  = '0;
        hgt_ra  = fifo_q;
        exc_we  = 1'b0;
        exc_wa  = p_reg[VTX_W-1:0];
        exc_wd  = '0;
        exc_ra  = fifo_q;
        fifo_wa = fhead_reg + fcnt_reg[VTX_W-1:0];

        new_exc = exc_q + amt_reg;
        enq_try = 1'b0;
        enq_v   = v_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && request.action == ACT_ADD)
                begin
                    if (ecount_reg >= CNT_W'(MAX_EDGES))
                        ovf_next = 1'b1;
                    else
                    begin
                        edge_we     = 1'b1;
                        ecount_next = ecount_reg + CNT_W'(1);
                    end
                end
                else if (run_req)
                begin
                    src_next    = request.source_vertex;
                    snk_next    = request.sink_vertex;
                    nv_next     = nv_eff;
                    p_next      = '0;
                    fhead_next  = '0;
                    fcnt_next   = '0;
                    queued_next = '0;
                    acc_next    = '0;
                    bad_next    = bad_run;
                end
            end
            ST_CLEAR:
            begin
                flow_we = 1'b1;
                if (p_reg < CNT_W'(MAX_VERTICES))
                begin
                    hgt_we = 1'b1;
                    exc_we = 1'b1;
                    hgt_wd = (p_reg[VTX_W-1:0] == src_reg) ? HGT_W'(nv_reg) : '0;
                end
                p_next = (p_reg[PAIR_W-1:0] == PAIR_W'(MAX_EDGES - 1)) ? '0
                                                                       : p_reg + CNT_W'(1);
            end
            ST_SAT_CHK:
            begin
                v_next   = edge_q.head;
                amt_next = EXC_W'(edge_q.cap);
                exc_ra   = edge_q.head;
                if (edge_q.tail == src_reg && usable && edge_q.cap != '0)
                begin
                    flow_we = 1'b1;
                    flow_wd = edge_q.cap;
                end
                else
                    p_next = p_reg + CNT_W'(1);
            end
            ST_SAT_UPD:
            begin
                exc_we  = 1'b1;
                exc_wa  = v_reg;
                exc_wd  = new_exc;
                enq_try = (new_exc > 0);
                p_next  = p_reg + CNT_W'(1);
            end
            ST_SAT_RD:
            begin
                if (scan_done)
                    p_next = p_reg;
            end
            ST_DEQ_POP:
            begin
                u_next              = fifo_q;
                fhead_next          = fhead_reg + VTX_W'(1);
                fcnt_next           = fcnt_reg - NV_W'(1);
                queued_next[fifo_q] = 1'b0;
            end
            ST_VTX_LD:
            begin
                uh_next   = hgt_q;
                uex_next  = exc_q;
                p_next    = '0;
                any_next  = 1'b0;
                minv_next = 1'b0;
            end
            ST_SCAN_CHK:
            begin
                slot_next = (edge_q.tail != u_reg);
                f_next    = flow_q;
                if (edge_q.tail == u_reg)
                begin
                    v_next     = edge_q.head;
                    resid_next = {1'b0, edge_q.cap} - {1'b0, flow_q};
                    hgt_ra     = edge_q.head;
                end
                else
                begin
                    v_next     = edge_q.tail;
                    resid_next = {1'b0, flow_q};
                    hgt_ra     = edge_q.tail;
                end
                if (!eligible)
                    p_next = p_reg + CNT_W'(1);
            end
            ST_HGT_CHK:
            begin
                exc_ra = v_reg;
                if (!minv_reg || hgt_q < min_reg)
                begin
                    min_next  = hgt_q;
                    minv_next = 1'b1;
                end
                if (uh_reg == hgt_q + HGT_W'(1))
                begin
                    any_next = 1'b1;
                    if (uex_reg > 0)
                    begin
                        amt_next = (resid_ext < uex_reg) ? resid_ext : uex_reg;
                        uex_next = uex_reg - ((resid_ext < uex_reg) ? resid_ext : uex_reg);
                        flow_we  = 1'b1;
                        flow_wd  = slot_reg
                            ? f_reg - CAP_W'((resid_ext < uex_reg) ? resid_ext : uex_reg)
                            : f_reg + CAP_W'((resid_ext < uex_reg) ? resid_ext : uex_reg);
                    end
                    else
                        p_next = p_reg + CNT_W'(1);
                end
                else
                    p_next = p_reg + CNT_W'(1);
            end
            ST_PUSH_UPD:
            begin
                exc_we  = 1'b1;
                exc_wa  = v_reg;
                exc_wd  = new_exc;
                enq_try = (new_exc > 0);
                p_next  = p_reg + CNT_W'(1);
            end
            ST_SCAN_END:
            begin
                p_next    = '0;
                any_next  = 1'b0;
                minv_next = 1'b0;
                if (!any_reg && minv_reg)
                begin
                    uh_next = min_reg + HGT_W'(1);
                    hgt_we  = 1'b1;
                    hgt_wa  = u_reg;
                    hgt_wd  = min_reg + HGT_W'(1);
                end
            end
            ST_WB:
            begin
                exc_we = 1'b1;
                exc_wa = u_reg;
                exc_wd = uex_reg;
            end
            ST_DEQ_RD:
            begin
                p_next = '0;
            end
            ST_SUM_ACC:
            begin
                if (usable && edge_q.tail == src_reg)
                    acc_next = acc_reg + ACC_W'(flow_q);
                else if (usable && edge_q.head == src_reg)
                    acc_next = acc_reg - ACC_W'(flow_q);
                p_next = p_reg + CNT_W'(1);
            end
            default:
            begin
            end
        endcase

        enq_ok = enq_try && enq_v != src_reg && enq_v != snk_reg && !queued_reg[enq_v]
              && fcnt_reg < NV_W'(MAX_VERTICES);
        fifo_we = enq_ok;
        if (enq_ok)
        begin
            queued_next[enq_v] = 1'b1;
            fcnt_next          = fcnt_reg + NV_W'(1);
        end
    end

    // outputs
    assign busy      = (state_reg != ST_IDLE);
    assign done      = (state_reg == ST_DONE);
    assign cfg_ready = 1'b1;
    assign result    = '{total_flow: bad_reg ? '0 : acc_reg[FLOW_W-1:0],
                         bad_terminal: bad_reg, table_overflow: ovf_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            vcount_reg <= NV_W'(MAX_VERTICES);
            ecount_reg <= '0;
            ovf_reg    <= 1'b0;
            fhead_reg  <= '0;
            fcnt_reg   <= '0;
            queued_reg <= '0;
            p_reg      <= '0;
            any_reg    <= 1'b0;
            minv_reg   <= 1'b0;
            bad_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            if (cfg_valid && cfg_ready)
                vcount_reg <= cfg_data;
            ecount_reg <= ecount_next;
            ovf_reg    <= ovf_next;
            fhead_reg  <= fhead_next;
            fcnt_reg   <= fcnt_next;
            queued_reg <= queued_next;
            p_reg      <= p_next;
            any_reg    <= any_next;
            minv_reg   <= minv_next;
            bad_reg    <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg   <= src_next;
        snk_reg   <= snk_next;
        nv_reg    <= nv_next;
        u_reg     <= u_next;
        v_reg     <= v_next;
        uh_reg    <= uh_next;
        uex_reg   <= uex_next;
        min_reg   <= min_next;
        resid_reg <= resid_next;
        f_reg     <= f_next;
        slot_reg  <= slot_next;
        amt_reg   <= amt_next;
        acc_reg   <= acc_next;
    end

    always_ff @(posedge clk)
    begin
        if (edge_we)
            edge_mem[edge_wa] <= edge_wd;
        edge_q <= edge_mem[edge_ra];
        if (flow_we)
            flow_mem[flow_wa] <= flow_wd;
        flow_q <= flow_mem[flow_ra];
        if (hgt_we)
            hgt_mem[hgt_wa] <= hgt_wd;
        hgt_q <= hgt_mem[hgt_ra];
        if (exc_we)
            exc_mem[exc_wa] <= exc_wd;
        exc_q <= exc_mem[exc_ra];
        if (fifo_we)
            fifo_mem[fifo_wa] <= enq_v;
        fifo_q <= fifo_mem[fhead_reg];
    end

    a_queue_marks: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(queued_reg) == 32'(fcnt_reg))
        else $error("queued marks disagree with queue fill");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe longer than one cycle");
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        run_req |=> busy)
        else $error("run request not taken up");
    a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ecount_reg <= CNT_W'(MAX_EDGES))
        else $error("edge count beyond table");
    a_add_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && request.action == ACT_ADD) |=> !busy)
        else $error("add-edge request left the block busy");

endmodule
